@@ design/intrusion_alarm_controller_defines.svh @@
// Assertion macros used by the alarm controller's checker file.
`ifndef INTRUSION_ALARM_CONTROLLER_DEFINES_SVH
`define INTRUSION_ALARM_CONTROLLER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and held off while rst_ni is low.
`define IAC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("intrusion alarm controller check failed");

// Next-cycle implication, sampled on clk_i and held off while rst_ni is low.
`define IAC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("intrusion alarm controller check failed");

`endif

@@ design/iac_pkg.sv @@
// Types and constants of the intrusion alarm controller.
package iac_pkg;

  typedef enum logic [2:0] {
    MODE_DISARMED = 3'd0,
    MODE_EXIT     = 3'd1,
    MODE_ARMED    = 3'd2,
    MODE_ENTRY    = 3'd3,
    MODE_ALARM    = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    CMD_TICK      = 3'd0,
    CMD_ARM       = 3'd1,
    CMD_DISARM    = 3'd2,
    CMD_INTRUSION = 3'd3,
    CMD_KEY       = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    RES_NONE     = 2'd0,
    RES_ACCEPTED = 2'd1,
    RES_REJECTED = 2'd2
  } code_res_e;

  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [CfgIdxW-1:0] CFG_PASSCODE    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_EXIT_DELAY  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ENTRY_DELAY = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_MAX_TRIES   = 2'd3;

  localparam logic [31:0] PASSCODE_RESET    = 32'h3132_3334;
  localparam logic [7:0]  EXIT_DELAY_RESET  = 8'd25;
  localparam logic [7:0]  ENTRY_DELAY_RESET = 8'd100;
  localparam logic [2:0]  MAX_TRIES_RESET   = 3'd3;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] key_char;
  } in_item_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       armed_led;
    logic       delay_led;
    logic       siren;
    logic [1:0] code_result;
    logic [2:0] tries_left;
  } out_item_t;

  typedef struct packed {
    logic [31:0] passcode;
    logic [7:0]  exit_delay_ticks;
    logic [7:0]  entry_delay_ticks;
    logic [2:0]  max_tries;
  } cfg_t;

  typedef struct packed {
    mode_e      mode;
    logic       code_pending;
    logic [2:0] try_count;
    logic [7:0] delay_count;
    logic       blink;
  } panel_state_t;

endpackage

@@ design/iac_core.sv @@
// Next-state and result logic for one event of the alarm panel.
module iac_core #(
  parameter int unsigned CODE_LENGTH = 4,
  parameter int unsigned KeyCntW     = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1
) (
  input  iac_pkg::cfg_t                     cfg_i,
  input  iac_pkg::in_item_t                 item_i,
  input  iac_pkg::panel_state_t             state_i,
  input  logic [CODE_LENGTH-1:0][7:0]       keys_i,
  input  logic [KeyCntW-1:0]                key_cnt_i,
  output iac_pkg::panel_state_t             state_o,
  output logic [CODE_LENGTH-1:0][7:0]       keys_o,
  output logic [KeyCntW-1:0]                key_cnt_o,
  output iac_pkg::out_item_t                result_o
);
  import iac_pkg::*;

  localparam int unsigned CodeW = 8 * CODE_LENGTH;

  logic [CodeW-1:0] entered;
  logic [CodeW-1:0] wanted;
  logic [63:0]      passcode_ext;
  logic             code_ok;
  logic             collect;
  logic [8:0]       tick_next;
  logic [7:0]       limit;
  logic [2:0]       try_next;
  code_res_e        res;

  // The last character completes the code, so it stands in the lowest byte.
  always_comb begin
    for (int i = 0; i < CODE_LENGTH; i++) begin
      entered[8*(CODE_LENGTH-1-i) +: 8] = (i == CODE_LENGTH - 1) ? item_i.key_char : keys_i[i];
    end
  end

  assign passcode_ext = {32'd0, cfg_i.passcode};
  assign wanted       = passcode_ext[CodeW-1:0];
  assign code_ok      = (entered == wanted);

  assign limit     = (state_i.mode == MODE_EXIT) ? cfg_i.exit_delay_ticks
                                                 : cfg_i.entry_delay_ticks;
  assign tick_next = {1'b0, state_i.delay_count} + 9'd1;
  assign try_next  = state_i.try_count + 3'd1;
  assign collect   = (state_i.mode == MODE_ENTRY) || (state_i.mode == MODE_ALARM) ||
                     (((state_i.mode == MODE_DISARMED) || (state_i.mode == MODE_ARMED)) &&
                      state_i.code_pending);

  always_comb begin
    state_o   = state_i;
    keys_o    = keys_i;
    key_cnt_o = key_cnt_i;
    res       = RES_NONE;
    unique case (item_i.command)
      CMD_TICK: begin
        if ((state_i.mode == MODE_EXIT) || (state_i.mode == MODE_ENTRY)) begin
          if (tick_next > {1'b0, limit}) begin
            state_o.delay_count = 8'd0;
            state_o.blink       = 1'b1;
            if (state_i.mode == MODE_EXIT) begin
              state_o.mode      = MODE_ARMED;
              state_o.try_count = 3'd0;
            end else begin
              state_o.mode         = MODE_ALARM;
              state_o.code_pending = 1'b0;
              keys_o               = '0;
              key_cnt_o            = '0;
            end
          end else begin
            state_o.delay_count = tick_next[7:0];
            state_o.blink       = ~state_i.blink;
          end
        end
      end
      CMD_ARM: begin
        if (state_i.mode == MODE_DISARMED) begin
          state_o.code_pending = 1'b1;
          keys_o               = '0;
          key_cnt_o            = '0;
        end
      end
      CMD_DISARM: begin
        if ((state_i.mode == MODE_ARMED) && !state_i.code_pending) begin
          state_o.code_pending = 1'b1;
          state_o.try_count    = 3'd0;
          keys_o               = '0;
          key_cnt_o            = '0;
        end
      end
      CMD_INTRUSION: begin
        if ((state_i.mode == MODE_ARMED) && !state_i.code_pending) begin
          state_o.mode        = MODE_ENTRY;
          state_o.delay_count = 8'd0;
          state_o.blink       = 1'b1;
          state_o.try_count   = 3'd0;
          keys_o              = '0;
          key_cnt_o           = '0;
        end
      end
      CMD_KEY: begin
        if (collect) begin
          if (key_cnt_i == KeyCntW'(CODE_LENGTH - 1)) begin
            keys_o    = '0;
            key_cnt_o = '0;
            res       = code_ok ? RES_ACCEPTED : RES_REJECTED;
            if (state_i.mode == MODE_DISARMED) begin
              state_o.code_pending = 1'b0;
              if (code_ok) begin
                state_o.mode        = MODE_EXIT;
                state_o.delay_count = 8'd0;
                state_o.blink       = 1'b1;
                state_o.try_count   = 3'd0;
              end
            end else if (code_ok) begin
              state_o.mode         = MODE_DISARMED;
              state_o.code_pending = 1'b0;
              state_o.try_count    = 3'd0;
              state_o.delay_count  = 8'd0;
              state_o.blink        = 1'b1;
            end else if (state_i.mode != MODE_ALARM) begin
              // The try counter wraps at eight, and a wrap also sounds the alarm.
              state_o.try_count = try_next;
              if ((try_next >= cfg_i.max_tries) || (try_next == 3'd0)) begin
                state_o.mode         = MODE_ALARM;
                state_o.code_pending = 1'b0;
                state_o.delay_count  = 8'd0;
                state_o.blink        = 1'b1;
              end
            end
          end else begin
            keys_o[key_cnt_i] = item_i.key_char;
            key_cnt_o         = key_cnt_i + KeyCntW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result_o.mode        = state_o.mode;
    result_o.armed_led   = (state_o.mode != MODE_DISARMED);
    result_o.delay_led   = state_o.blink;
    result_o.siren       = (state_o.mode == MODE_ALARM);
    result_o.code_result = res;
    result_o.tries_left  = (cfg_i.max_tries > state_o.try_count)
                           ? (cfg_i.max_tries - state_o.try_count) : 3'd0;
  end

endmodule

@@ design/intrusion_alarm_controller.sv @@
// Top level of the intrusion alarm controller: event register, panel state and result register.
//
//   channel   direction  handshake                  payload
//   in        input      in_valid_i / in_stall_o    in_item_i  (command, key_char)
//   out       output     out_valid_o / out_stall_i  out_item_o (mode, leds, siren, result, tries)
//   cfg       input      cfg_we_i                   cfg_idx_i, cfg_data_i
//
// One event per cycle while the result side is not stalled; an event waits in the event
// register and its result leaves from the result register.
// The rate is set by the single pass of next-state logic between those two registers.
// After reset the panel is disarmed with the default code and delays; no clearing pass.
// A stalled result holds the event register; events are taken again once the result moves.
module intrusion_alarm_controller #(
  parameter int unsigned CODE_LENGTH = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  iac_pkg::in_item_t                in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output iac_pkg::out_item_t               out_item_o,
  input  logic                             cfg_we_i,
  input  logic [iac_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [iac_pkg::CfgDataW-1:0]     cfg_data_i
);
  import iac_pkg::*;

  localparam int unsigned KeyCntW = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;

  cfg_t                        cfg_q;
  logic                        in_valid_q;
  in_item_t                    in_item_q;
  logic                        out_valid_q;
  out_item_t                   out_item_q;
  panel_state_t                state_q, state_d;
  logic [CODE_LENGTH-1:0][7:0] keys_q, keys_d;
  logic [KeyCntW-1:0]          key_cnt_q, key_cnt_d;
  out_item_t                   result_d;
  logic                        advance;
  logic                        in_take;

  // An event moves into the result register whenever that register is free or draining.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.passcode          <= PASSCODE_RESET;
      cfg_q.exit_delay_ticks  <= EXIT_DELAY_RESET;
      cfg_q.entry_delay_ticks <= ENTRY_DELAY_RESET;
      cfg_q.max_tries         <= MAX_TRIES_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PASSCODE:    cfg_q.passcode          <= cfg_data_i[31:0];
        CFG_EXIT_DELAY:  cfg_q.exit_delay_ticks  <= cfg_data_i[7:0];
        CFG_ENTRY_DELAY: cfg_q.entry_delay_ticks <= cfg_data_i[7:0];
        CFG_MAX_TRIES:   cfg_q.max_tries         <= cfg_data_i[2:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= in_item_i;
    end
    if (advance) begin
      out_item_q <= result_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode         <= MODE_DISARMED;
      state_q.code_pending <= 1'b0;
      state_q.try_count    <= 3'd0;
      state_q.delay_count  <= 8'd0;
      state_q.blink        <= 1'b1;
      keys_q               <= '0;
      key_cnt_q            <= '0;
    end else if (advance) begin
      state_q   <= state_d;
      keys_q    <= keys_d;
      key_cnt_q <= key_cnt_d;
    end
  end

  iac_core #(
    .CODE_LENGTH (CODE_LENGTH),
    .KeyCntW     (KeyCntW)
  ) u_core (
    .cfg_i     (cfg_q),
    .item_i    (in_item_q),
    .state_i   (state_q),
    .keys_i    (keys_q),
    .key_cnt_i (key_cnt_q),
    .state_o   (state_d),
    .keys_o    (keys_d),
    .key_cnt_o (key_cnt_d),
    .result_o  (result_d)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

@@ design/iac_assert.sv @@
// Port-level assertions for the intrusion alarm controller and their bind.
`include "intrusion_alarm_controller_defines.svh"

module iac_assert (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input iac_pkg::out_item_t   out_item_o
);
  import iac_pkg::*;

  // The input side only backs up when the result side is stalled.
  `IAC_ASSERT_NOW(a_stall_only_from_out, !out_stall_i, !in_stall_o)

  // A result waiting on a stall keeps its value.
  `IAC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_item_o))

  // The siren follows alarm mode, and every mode but disarmed lights the armed LED.
  `IAC_ASSERT_NOW(a_siren_mode, out_valid_o, out_item_o.siren == (out_item_o.mode == MODE_ALARM))
  `IAC_ASSERT_NOW(a_armed_led_mode, out_valid_o, out_item_o.armed_led == (out_item_o.mode != MODE_DISARMED))

endmodule

bind intrusion_alarm_controller iac_assert u_iac_assert (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
